// ===== hw/rtl/kdef_pkg.sv =====
// Shared types and constants for the key debounce and event queue block.
// No dependencies; every other file of the block imports this package.

package kdef_pkg;

  // Key set: three buttons, then stick up, down, left, right.
  localparam int NUM_KEYS    = 7;
  localparam int NUM_BUTTONS = 3;
  localparam int KEY_W       = 3;
  localparam int CODE_W      = 5;
  localparam int FILT_W      = 4;
  localparam int HOLD_W      = 16;
  localparam int REP_W       = 8;
  localparam int ADC_W       = 12;
  localparam int BTN_W       = 3;
  localparam int ACT_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Marker for "no key is the single active key" on a scan tick.
  localparam logic [KEY_W-1:0] NO_KEY = 3'd7;

  // Action codes of an input beat.
  localparam logic [ACT_W-1:0] ACT_SCAN  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_LONG   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_REPEAT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_LONG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_REPEAT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_HIGH    = 3'd5;

  // Configuration reset values.
  localparam logic [HOLD_W-1:0] RST_BUTTON_LONG   = 16'd100;
  localparam logic [REP_W-1:0]  RST_BUTTON_REPEAT = 8'd0;
  localparam logic [HOLD_W-1:0] RST_STICK_LONG    = 16'd50;
  localparam logic [REP_W-1:0]  RST_STICK_REPEAT  = 8'd6;
  localparam logic [ADC_W-1:0]  RST_STICK_LOW     = 12'd12;
  localparam logic [ADC_W-1:0]  RST_STICK_HIGH    = 12'd3971;

  typedef struct packed {
    logic [HOLD_W-1:0] button_long_time;
    logic [REP_W-1:0]  button_repeat_period;
    logic [HOLD_W-1:0] stick_long_time;
    logic [REP_W-1:0]  stick_repeat_period;
    logic [ADC_W-1:0]  stick_low_threshold;
    logic [ADC_W-1:0]  stick_high_threshold;
  } cfg_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] down_key;
  } cmd_t;

  // Release codes are 3*k+2 for the seven keys.
  function automatic logic is_release(input logic [CODE_W-1:0] code);
    logic rel;
    case (code)
      5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20: rel = 1'b1;
      default: rel = 1'b0;
    endcase
    return rel;
  endfunction

endpackage

// ===== hw/rtl/kdef_chan_if.sv =====
// Valid/ready channel interfaces for the input beats and the result beats.
// Depends on kdef_pkg for field widths.

interface kdef_in_if import kdef_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BTN_W-1:0]  button_levels;
  logic [ADC_W-1:0]  stick_vertical;
  logic [ADC_W-1:0]  stick_horizontal;

  modport source (output valid, action, button_levels, stick_vertical, stick_horizontal,
                  input ready);
  modport sink   (input valid, action, button_levels, stick_vertical, stick_horizontal,
                  output ready);
endinterface

interface kdef_out_if import kdef_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] key_code;
  logic              queue_empty;

  modport source (output valid, key_code, queue_empty, input ready);
  modport sink   (input valid, key_code, queue_empty, output ready);
endinterface

// ===== hw/rtl/kdef_front.sv =====
// Front end: takes input beats and classifies them into commands.
// Depends on kdef_pkg and the channel interfaces in kdef_chan_if.sv.

module kdef_front import kdef_pkg::*; (
  input  cfg_t           cfg,
  kdef_in_if.sink        in_ch,
  output logic           cmd_valid,
  output cmd_t           cmd,
  input  logic           cmd_ready
);

  logic [NUM_KEYS-1:0] active;
  logic [KEY_W-1:0]    which;
  logic [KEY_W-1:0]    count;

  // Raw activity of each key on this sample.
  always_comb begin
    active[0] = ~in_ch.button_levels[0];
    active[1] = ~in_ch.button_levels[1];
    active[2] = ~in_ch.button_levels[2];
    active[3] = in_ch.stick_vertical < cfg.stick_low_threshold;
    active[4] = in_ch.stick_vertical > cfg.stick_high_threshold;
    active[5] = in_ch.stick_horizontal < cfg.stick_low_threshold;
    active[6] = in_ch.stick_horizontal > cfg.stick_high_threshold;
  end

  // A key is down only when it is the one active key of all seven.
  always_comb begin
    count = '0;
    which = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (active[k]) begin
        count = count + 1'b1;
        which = KEY_W'(k);
      end
    end
  end

  assign cmd.action   = in_ch.action;
  assign cmd.down_key = (count == KEY_W'(1)) ? which : NO_KEY;
  assign cmd_valid    = in_ch.valid;
  assign in_ch.ready  = cmd_ready;

endmodule

// ===== hw/rtl/kdef_cmd_queue.sv =====
// Two-entry command queue between the classifier and the key/queue engine.
// Depends on kdef_pkg for the command type.

module kdef_cmd_queue import kdef_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_ready
);

  cmd_t       slot_r [2];
  logic       head_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;
  logic       tail;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slot_r[head_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign tail       = head_r ^ count_r[0];

  // Control: head index and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_pop) begin
        head_r <= ~head_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Payload slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[tail] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/kdef_back.sv =====
// Back end: walks the seven keys serially on a scan, runs the event memory
// and holds the result register. Depends on kdef_pkg and kdef_chan_if.sv.

module kdef_back import kdef_pkg::*; #(
  parameter int FILTER_TICKS = 5,
  parameter int QUEUE_DEPTH  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     cmd_valid,
  input  cmd_t     cmd,
  output logic     cmd_ready,
  kdef_out_if.source out_ch
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILT_W-1:0] FILT_LO  = FILT_W'(FILTER_TICKS);
  localparam logic [FILT_W-1:0] FILT_HI  = FILT_W'(2 * FILTER_TICKS);
  localparam logic [FILT_W-1:0] FILT_RST = FILT_W'(FILTER_TICKS / 2);
  localparam logic [KEY_W-1:0]  LAST_KEY = KEY_W'(NUM_KEYS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_PEND   = 3'd2;
  localparam logic [2:0] ST_RDMEM  = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // Per-key debounce state.
  logic [FILT_W-1:0] filt_r    [NUM_KEYS];
  logic              pressed_r [NUM_KEYS];
  logic [HOLD_W-1:0] hold_r    [NUM_KEYS];
  logic [REP_W-1:0]  rep_r     [NUM_KEYS];

  // Event memory and its pointers.
  logic [CODE_W-1:0] mem [QUEUE_DEPTH];
  logic [CODE_W-1:0] rd_data_r;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic              cleared_r, cleared_nxt;

  // Sequencer.
  logic [2:0]        state_r, state_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [KEY_W-1:0]  down_r, down_nxt;
  logic [CODE_W-1:0] pend_r, pend_nxt;
  logic [CODE_W-1:0] res_r, res_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] out_code_r, out_code_nxt;
  logic              out_empty_r, out_empty_nxt;

  // Key step signals.
  logic              key_we;
  logic [FILT_W-1:0] f_cur, f_nxt;
  logic              p_cur, p_nxt;
  logic [HOLD_W-1:0] h_cur, h_nxt, h_inc;
  logic [REP_W-1:0]  r_cur, r_nxt, r_inc;
  logic [HOLD_W-1:0] long_time;
  logic [REP_W-1:0]  period;
  logic [CODE_W-1:0] base;
  logic              key_down;
  logic              last_key;
  logic              a_valid, b_valid;
  logic [CODE_W-1:0] a_code, b_code;

  // Memory push port.
  logic              push_en;
  logic [CODE_W-1:0] push_code;
  logic              full;
  logic              do_push;
  logic              mem_rd_en;
  logic [CODE_W-1:0] rd_code;

  assign f_cur     = filt_r[key_r];
  assign p_cur     = pressed_r[key_r];
  assign h_cur     = hold_r[key_r];
  assign r_cur     = rep_r[key_r];
  assign h_inc     = h_cur + 1'b1;
  assign r_inc     = r_cur + 1'b1;
  assign long_time = (key_r < KEY_W'(NUM_BUTTONS)) ? cfg.button_long_time
                                                    : cfg.stick_long_time;
  assign period    = (key_r < KEY_W'(NUM_BUTTONS)) ? cfg.button_repeat_period
                                                    : cfg.stick_repeat_period;
  assign base      = (CODE_W'(key_r) << 1) + CODE_W'(key_r);
  assign key_down  = (down_r == key_r);
  assign last_key  = (key_r == LAST_KEY);
  assign full      = (next_ptr(wr_ptr_r) == rd_ptr_r);
  assign do_push   = push_en && !full;
  assign rd_code   = (is_release(rd_data_r) && cleared_r) ? '0 : rd_data_r;

  // Debounce, long press and repeat update for the key under the walker.
  always_comb begin
    f_nxt   = f_cur;
    p_nxt   = p_cur;
    h_nxt   = h_cur;
    r_nxt   = r_cur;
    a_valid = 1'b0;
    b_valid = 1'b0;
    a_code  = base + CODE_W'(1);
    b_code  = base + CODE_W'(3);
    if (key_down) begin
      if (f_cur < FILT_LO) begin
        f_nxt = FILT_LO;
      end else if (f_cur < FILT_HI) begin
        f_nxt = f_cur + 1'b1;
      end else begin
        if (!p_cur) begin
          p_nxt   = 1'b1;
          a_valid = 1'b1;
        end
        if (long_time != '0) begin
          if (h_cur < long_time) begin
            h_nxt   = h_inc;
            b_valid = (h_inc == long_time);
          end else if (period != '0) begin
            // Repeat reuses the press code.
            if (r_inc >= period) begin
              r_nxt   = '0;
              b_valid = 1'b1;
              b_code  = base + CODE_W'(1);
            end else begin
              r_nxt = r_inc;
            end
          end
        end
      end
    end else begin
      if (f_cur > FILT_LO) begin
        f_nxt = FILT_LO;
      end else if (f_cur != '0) begin
        f_nxt = f_cur - 1'b1;
      end else if (p_cur) begin
        p_nxt   = 1'b0;
        a_valid = 1'b1;
        a_code  = base + CODE_W'(2);
      end
      h_nxt = '0;
      r_nxt = '0;
    end
  end

  // Sequencer: one command at a time, one key per cycle save for pend steps.
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    down_nxt      = down_r;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = do_push ? next_ptr(wr_ptr_r) : wr_ptr_r;
    cleared_nxt   = cleared_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_code_nxt  = out_code_r;
    out_empty_nxt = out_empty_r;
    cmd_ready     = 1'b0;
    key_we        = 1'b0;
    push_en       = 1'b0;
    push_code     = a_code;
    mem_rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          down_nxt = cmd.down_key;
          res_nxt  = '0;
          case (cmd.action)
            ACT_SCAN: begin
              key_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            ACT_READ: begin
              if (rd_ptr_r != wr_ptr_r) begin
                mem_rd_en = 1'b1;
                state_nxt = ST_RDMEM;
              end else begin
                state_nxt = ST_RESULT;
              end
            end
            ACT_CLEAR: begin
              rd_ptr_nxt  = wr_ptr_r;
              cleared_nxt = 1'b1;
              state_nxt   = ST_RESULT;
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        key_we = 1'b1;
        if (a_valid && b_valid) begin
          // Press and long press in one tick: the second code waits in pend_r.
          push_en   = 1'b1;
          pend_nxt  = b_code;
          state_nxt = ST_PEND;
        end else begin
          push_en   = a_valid || b_valid;
          push_code = a_valid ? a_code : b_code;
          key_nxt   = key_r + 1'b1;
          state_nxt = last_key ? ST_RESULT : ST_SCAN;
        end
      end
      ST_PEND: begin
        push_en   = 1'b1;
        push_code = pend_r;
        key_nxt   = key_r + 1'b1;
        state_nxt = last_key ? ST_RESULT : ST_SCAN;
      end
      ST_RDMEM: begin
        res_nxt     = rd_code;
        rd_ptr_nxt  = next_ptr(rd_ptr_r);
        cleared_nxt = 1'b0;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = res_r;
          out_empty_nxt = (rd_ptr_r == wr_ptr_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers and per-key state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cleared_r   <= 1'b1;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        filt_r[k]    <= FILT_RST;
        pressed_r[k] <= 1'b0;
        hold_r[k]    <= '0;
        rep_r[k]     <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      cleared_r   <= cleared_nxt;
      out_valid_r <= out_valid_nxt;
      if (key_we) begin
        filt_r[key_r]    <= f_nxt;
        pressed_r[key_r] <= p_nxt;
        hold_r[key_r]    <= h_nxt;
        rep_r[key_r]     <= r_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    down_r      <= down_nxt;
    pend_r      <= pend_nxt;
    res_r       <= res_nxt;
    out_code_r  <= out_code_nxt;
    out_empty_r <= out_empty_nxt;
  end

  // Event memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_code;
    end
    if (mem_rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.key_code    = out_code_r;
  assign out_ch.queue_empty = out_empty_r;

  // A code offered while the queue is full must not move the write pointer.
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    push_en && full |=> $stable(wr_ptr_r))
    else $error("write pointer moved on a full queue");

  // The debounce counter stays within its hysteresis band.
  a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> f_cur <= FILT_HI)
    else $error("filter count beyond twice the filter time");

  // A result is loaded only from the result state and only into a free slot.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_code_r) && $stable(out_empty_r))
    else $error("result overwritten while waiting");

  // Popping a command is only possible while the engine is idle.
  a_cmd_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && cmd_ready |-> state_r == ST_IDLE)
    else $error("command taken while busy");

endmodule

// ===== hw/rtl/key_debounce_event_fifo.sv =====
// Seven-key scanner with debouncing, long press, auto repeat and an event queue.
// Every input beat (scan tick, read or clear) gives exactly one result beat.
// A read of a non-empty queue passes through the memory read state to the
// result state; a scan tick walks the seven keys in the serial debounce
// engine, with an extra pend step for each key that queues a press and a
// long press on the same tick, since the event memory has a single write
// port. A two-entry command queue lets input beats be taken while the engine
// works or a result waits. The event queue holds QUEUE_DEPTH-1 codes; codes
// produced while it is full are dropped. There is no clearing pass after reset.

module key_debounce_event_fifo import kdef_pkg::*; #(
  parameter int FILTER_TICKS = 5,
  parameter int QUEUE_DEPTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  kdef_in_if.sink               in_ch,
  kdef_out_if.source            out_ch
);

  cfg_t cfg_r;
  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_long_time     <= RST_BUTTON_LONG;
      cfg_r.button_repeat_period <= RST_BUTTON_REPEAT;
      cfg_r.stick_long_time      <= RST_STICK_LONG;
      cfg_r.stick_repeat_period  <= RST_STICK_REPEAT;
      cfg_r.stick_low_threshold  <= RST_STICK_LOW;
      cfg_r.stick_high_threshold <= RST_STICK_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUTTON_LONG:   cfg_r.button_long_time     <= cfg_wdata;
        CFG_BUTTON_REPEAT: cfg_r.button_repeat_period <= cfg_wdata[REP_W-1:0];
        CFG_STICK_LONG:    cfg_r.stick_long_time      <= cfg_wdata;
        CFG_STICK_REPEAT:  cfg_r.stick_repeat_period  <= cfg_wdata[REP_W-1:0];
        CFG_STICK_LOW:     cfg_r.stick_low_threshold  <= cfg_wdata[ADC_W-1:0];
        CFG_STICK_HIGH:    cfg_r.stick_high_threshold <= cfg_wdata[ADC_W-1:0];
        default: ;
      endcase
    end
  end

  kdef_front u_front (
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .cmd_valid (fq_valid),
    .cmd       (fq_cmd),
    .cmd_ready (fq_ready)
  );

  kdef_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_cmd   (fq_cmd),
    .push_ready (fq_ready),
    .pop_valid  (qb_valid),
    .pop_cmd    (qb_cmd),
    .pop_ready  (qb_ready)
  );

  kdef_back #(
    .FILTER_TICKS (FILTER_TICKS),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (qb_valid),
    .cmd       (qb_cmd),
    .cmd_ready (qb_ready),
    .out_ch    (out_ch)
  );

endmodule
